### hdl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and helpers of the boot sequence supervisor.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LIMIT_W     = 16;
	localparam int GAP_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [LIMIT_W-1:0]     limit_t;
	typedef logic [GAP_W-1:0]       gap_t;

	localparam count_t CNT_MAX = '1;

	localparam limit_t RST_PRESS_MIN   = limit_t'(16);
	localparam limit_t RST_PRESS_MAX   = limit_t'(500);
	localparam limit_t RST_RISE_LIMIT  = limit_t'(50);
	localparam limit_t RST_READY_LIMIT = limit_t'(550);
	localparam gap_t   RST_STEP_GAP    = gap_t'(5);
	localparam gap_t   RST_SETTLE_GAP  = gap_t'(10);
	localparam gap_t   RST_RESET_PULSE = gap_t'(100);

	typedef enum logic [2:0] {
		PH_PRESS = 3'd0,
		PH_GOOD  = 3'd1,
		PH_READY = 3'd2,
		PH_IDLE  = 3'd3,
		PH_FAIL  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		FS_STROBE_HI = 3'd0,
		FS_STROBE_LO = 3'd1,
		FS_RAIL_HI   = 3'd2,
		FS_RESET_LO  = 3'd3,
		FS_RESET_HI  = 3'd4
	} fail_step_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_MIN   = 3'd0,
		CFG_PRESS_MAX   = 3'd1,
		CFG_RISE_LIMIT  = 3'd2,
		CFG_READY_LIMIT = 3'd3,
		CFG_STEP_GAP    = 3'd4,
		CFG_SETTLE_GAP  = 3'd5,
		CFG_RESET_PULSE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		limit_t press_min_ms;
		limit_t press_max_ms;
		limit_t rise_limit_ticks;
		limit_t ready_limit_ticks;
		gap_t   step_gap_ms;
		gap_t   settle_gap_ms;
		gap_t   reset_pulse_ms;
	} cfg_t;

	typedef struct packed {
		logic ms_tick;
		logic coarse_tick;
		logic button_level;
		logic power_good;
		logic ready_level;
	} item_t;

	typedef struct packed {
		logic   rail_enable;
		logic   strobe_pin;
		logic   reset_out_n;
		phase_t phase;
	} result_t;

	function automatic count_t sat_inc(count_t v);
		return (v == CNT_MAX) ? v : count_t'(v + count_t'(1));
	endfunction

	function automatic logic cnt_gt(count_t c, limit_t lim);
		return CMP_W'(c) > CMP_W'(lim);
	endfunction

	function automatic logic cnt_lt(count_t c, limit_t lim);
		return CMP_W'(c) < CMP_W'(lim);
	endfunction

endpackage

### hdl/bss_in_if.sv
// ----------------------------------------------------------------------------
// bss_in_if
// Sample channel: one beat carries the tick and pin levels of one step.
// ----------------------------------------------------------------------------
interface bss_in_if;
	logic valid;
	logic ready;
	logic ms_tick;
	logic coarse_tick;
	logic button_level;
	logic power_good;
	logic ready_level;

	modport source (output valid, output ms_tick, output coarse_tick,
		output button_level, output power_good, output ready_level, input ready);
	modport sink (input valid, input ms_tick, input coarse_tick,
		input button_level, input power_good, input ready_level, output ready);
endinterface

### hdl/bss_out_if.sv
// ----------------------------------------------------------------------------
// bss_out_if
// Result channel: one beat carries the pin levels and phase after a step.
// ----------------------------------------------------------------------------
interface bss_out_if;
	logic       valid;
	logic       ready;
	logic       rail_enable;
	logic       strobe_pin;
	logic       reset_out_n;
	logic [2:0] phase;

	modport source (output valid, output rail_enable, output strobe_pin,
		output reset_out_n, output phase, input ready);
	modport sink (input valid, input rail_enable, input strobe_pin,
		input reset_out_n, input phase, output ready);
endinterface

### hdl/bss_cfg_if.sv
// ----------------------------------------------------------------------------
// bss_cfg_if
// Register write channel: one beat writes at most one register.
// ----------------------------------------------------------------------------
interface bss_cfg_if;
	import bss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/bss_cfg_regs.sv
// ----------------------------------------------------------------------------
// bss_cfg_regs
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module bss_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	bss_cfg_if.sink       cfg,
	output bss_pkg::cfg_t regs
);
	import bss_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.press_min_ms      <= RST_PRESS_MIN;
			regs_q.press_max_ms      <= RST_PRESS_MAX;
			regs_q.rise_limit_ticks  <= RST_RISE_LIMIT;
			regs_q.ready_limit_ticks <= RST_READY_LIMIT;
			regs_q.step_gap_ms       <= RST_STEP_GAP;
			regs_q.settle_gap_ms     <= RST_SETTLE_GAP;
			regs_q.reset_pulse_ms    <= RST_RESET_PULSE;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PRESS_MIN:   regs_q.press_min_ms      <= limit_t'(cfg.data);
				CFG_PRESS_MAX:   regs_q.press_max_ms      <= limit_t'(cfg.data);
				CFG_RISE_LIMIT:  regs_q.rise_limit_ticks  <= limit_t'(cfg.data);
				CFG_READY_LIMIT: regs_q.ready_limit_ticks <= limit_t'(cfg.data);
				CFG_STEP_GAP:    regs_q.step_gap_ms       <= cfg.data[GAP_W-1:0];
				CFG_SETTLE_GAP:  regs_q.settle_gap_ms     <= cfg.data[GAP_W-1:0];
				CFG_RESET_PULSE: regs_q.reset_pulse_ms    <= cfg.data[GAP_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

### hdl/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Supervisor state, counters and pin registers; one update per step.
// ----------------------------------------------------------------------------
module bss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  bss_pkg::item_t   item,
	input  bss_pkg::cfg_t    regs,
	output bss_pkg::result_t cur,
	output bss_pkg::result_t nxt
);
	import bss_pkg::*;

	phase_t     phase_q, phase_d;
	count_t     press_q, press_d;
	count_t     coarse_q, coarse_d;
	fail_step_t step_q, step_d;
	gap_t       gap_q, gap_d;
	logic       rail_q, rail_d;
	logic       strobe_q, strobe_d;
	logic       rst_q, rst_d;

	gap_t       gap_sel;
	gap_t       gap_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PRESS;
			press_q  <= '0;
			coarse_q <= '0;
			step_q   <= FS_STROBE_HI;
			gap_q    <= '0;
			rail_q   <= 1'b1;
			strobe_q <= 1'b0;
			rst_q    <= 1'b1;
		end else if (step_en) begin
			phase_q  <= phase_d;
			press_q  <= press_d;
			coarse_q <= coarse_d;
			step_q   <= step_d;
			gap_q    <= gap_d;
			rail_q   <= rail_d;
			strobe_q <= strobe_d;
			rst_q    <= rst_d;
		end
	end

	always_comb begin
		case (step_q) inside
			FS_STROBE_HI, FS_STROBE_LO, FS_RAIL_HI: gap_sel = regs.step_gap_ms;
			FS_RESET_LO:                            gap_sel = regs.settle_gap_ms;
			default:                                gap_sel = regs.reset_pulse_ms;
		endcase
		gap_inc = gap_t'(gap_q + gap_t'(1));
	end

	always_comb begin
		phase_d  = phase_q;
		press_d  = press_q;
		coarse_d = coarse_q;
		step_d   = step_q;
		gap_d    = gap_q;
		rail_d   = rail_q;
		strobe_d = strobe_q;
		rst_d    = rst_q;

		unique case (phase_q)
			PH_PRESS: begin
				if (!item.button_level) begin
					if (item.ms_tick)
						press_d = sat_inc(press_q);
				end else begin
					if (cnt_gt(press_q, regs.press_min_ms) &&
						cnt_lt(press_q, regs.press_max_ms)) begin
						phase_d  = PH_GOOD;
						coarse_d = '0;
					end
					press_d = '0;
				end
			end
			PH_GOOD: begin
				if (item.power_good) begin
					phase_d  = PH_READY;
					coarse_d = '0;
				end else if (cnt_gt(coarse_q, regs.rise_limit_ticks)) begin
					phase_d  = PH_FAIL;
					coarse_d = '0;
					step_d   = FS_STROBE_HI;
					gap_d    = '0;
					rail_d   = 1'b0;
				end else if (item.coarse_tick) begin
					coarse_d = sat_inc(coarse_q);
				end
			end
			PH_READY: begin
				if (cnt_gt(coarse_q, regs.ready_limit_ticks) || !item.power_good) begin
					phase_d  = PH_FAIL;
					coarse_d = '0;
					step_d   = FS_STROBE_HI;
					gap_d    = '0;
					rail_d   = 1'b0;
				end else if (!item.ready_level) begin
					phase_d  = PH_IDLE;
					coarse_d = '0;
				end else if (item.coarse_tick) begin
					coarse_d = sat_inc(coarse_q);
				end
			end
			PH_IDLE: ;
			PH_FAIL: begin
				if (item.ms_tick) begin
					if ((gap_inc < gap_sel) && (gap_inc != '0)) begin
						gap_d = gap_inc;
					end else begin
						gap_d  = '0;
						step_d = fail_step_t'(step_q + 3'd1);
						case (step_q)
							FS_STROBE_HI: strobe_d = 1'b1;
							FS_STROBE_LO: strobe_d = 1'b0;
							FS_RAIL_HI:   rail_d   = 1'b1;
							FS_RESET_LO:  rst_d    = 1'b0;
							default: begin
								rst_d   = 1'b1;
								phase_d = PH_PRESS;
								press_d = '0;
								step_d  = FS_STROBE_HI;
							end
						endcase
					end
				end
			end
			default: phase_d = PH_PRESS;
		endcase
	end

	assign cur = '{rail_enable: rail_q, strobe_pin: strobe_q, reset_out_n: rst_q,
		phase: phase_q};
	assign nxt = '{rail_enable: rail_d, strobe_pin: strobe_d, reset_out_n: rst_d,
		phase: phase_d};
endmodule

### hdl/boot_sequence_supervisor_unit.sv
// ----------------------------------------------------------------------------
// boot_sequence_supervisor_unit
// Power-up supervisor: press timing, power-good and ready supervision,
// failure pin sequence.
// ----------------------------------------------------------------------------
//   channel  dir  beat
//   req      in   one step: ms_tick, coarse_tick, button_level, power_good,
//                 ready_level
//   rsp      out  pins and phase after that step
//   cfg      in   register write: index, data
//
// One beat per cycle sustained while rsp is not stalled; a result passes
// through the sample register and then the result register.
// arst_n resets state, counters, pins and both valid flags; registers take
// their default values. rsp stalls hold the result register and back up
// into the sample register, then drop req.ready. cfg is always ready.
// ----------------------------------------------------------------------------
module boot_sequence_supervisor_unit (
	input  logic      clk,
	input  logic      arst_n,
	bss_in_if.sink    req,
	bss_out_if.source rsp,
	bss_cfg_if.sink   cfg
);
	import bss_pkg::*;

	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t cur;
	result_t nxt;
	result_t res_q;
	logic    out_valid_q;

	bss_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.regs    (regs),
		.cur     (cur),
		.nxt     (nxt)
	);

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= '{ms_tick: req.ms_tick, coarse_tick: req.coarse_tick,
				button_level: req.button_level, power_good: req.power_good,
				ready_level: req.ready_level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= nxt;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.rail_enable = res_q.rail_enable;
	assign rsp.strobe_pin  = res_q.strobe_pin;
	assign rsp.reset_out_n = res_q.reset_out_n;
	assign rsp.phase       = res_q.phase;

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cur.phase == PH_IDLE |=> cur.phase == PH_IDLE)
		else $error("idle phase left");

	a_pins_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(!cur.rail_enable || cur.strobe_pin || !cur.reset_out_n) |->
		cur.phase == PH_FAIL)
		else $error("failure pin levels outside failure phase");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cur))
		else $error("state moved without a step");
endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boot sequence supervisor. A beat-level
// predictor follows every accepted sample beat; each result beat is checked
// in order against it. A short directed pass walks press judging, both
// timeouts and the whole failure pin sequence. Random passes then run
// press/power-good/ready sequences over several register settings and
// idle/stall mixes. Idle is entered only in the last pass, as it holds
// until reset.
// ----------------------------------------------------------------------------
module tb;
	import bss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int GOAL_CAP    = 80;
	localparam int HOLD_CYCLES = 80;

	class supervisor_scoreboard;
		cfg_t       regs;
		phase_t     ph;
		count_t     press_cnt;
		count_t     coarse_cnt;
		fail_step_t fstep;
		gap_t       gap_cnt;
		logic       rail;
		logic       strobe;
		logic       rst_n;
		result_t    pin_q[$];
		int         errors;

		function new();
			regs.press_min_ms      = RST_PRESS_MIN;
			regs.press_max_ms      = RST_PRESS_MAX;
			regs.rise_limit_ticks  = RST_RISE_LIMIT;
			regs.ready_limit_ticks = RST_READY_LIMIT;
			regs.step_gap_ms       = RST_STEP_GAP;
			regs.settle_gap_ms     = RST_SETTLE_GAP;
			regs.reset_pulse_ms    = RST_RESET_PULSE;
			ph         = PH_PRESS;
			press_cnt  = '0;
			coarse_cnt = '0;
			fstep      = FS_STROBE_HI;
			gap_cnt    = '0;
			rail       = 1'b1;
			strobe     = 1'b0;
			rst_n      = 1'b1;
			errors     = 0;
		endfunction

		function int pending();
			return pin_q.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_PRESS_MIN:   regs.press_min_ms      = val;
				CFG_PRESS_MAX:   regs.press_max_ms      = val;
				CFG_RISE_LIMIT:  regs.rise_limit_ticks  = val;
				CFG_READY_LIMIT: regs.ready_limit_ticks = val;
				CFG_STEP_GAP:    regs.step_gap_ms       = val[7:0];
				CFG_SETTLE_GAP:  regs.settle_gap_ms     = val[7:0];
				CFG_RESET_PULSE: regs.reset_pulse_ms    = val[7:0];
				default: ;
			endcase
		endfunction

		function count_t bump(count_t v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function void start_fail();
			ph         = PH_FAIL;
			coarse_cnt = '0;
			fstep      = FS_STROBE_HI;
			gap_cnt    = '0;
			rail       = 1'b0;
		endfunction

		function void note_input(item_t it);
			result_t r;
			gap_t    lim;
			case (ph)
				PH_PRESS: begin
					if (!it.button_level) begin
						if (it.ms_tick)
							press_cnt = bump(press_cnt);
					end else begin
						if (press_cnt > regs.press_min_ms && press_cnt < regs.press_max_ms) begin
							ph         = PH_GOOD;
							coarse_cnt = '0;
						end
						press_cnt = '0;
					end
				end
				PH_GOOD: begin
					if (it.power_good) begin
						ph         = PH_READY;
						coarse_cnt = '0;
					end else if (coarse_cnt > regs.rise_limit_ticks)
						start_fail();
					else if (it.coarse_tick)
						coarse_cnt = bump(coarse_cnt);
				end
				PH_READY: begin
					if (coarse_cnt > regs.ready_limit_ticks || !it.power_good)
						start_fail();
					else if (!it.ready_level) begin
						ph         = PH_IDLE;
						coarse_cnt = '0;
					end else if (it.coarse_tick)
						coarse_cnt = bump(coarse_cnt);
				end
				PH_IDLE: ;
				PH_FAIL: begin
					if (it.ms_tick) begin
						case (fstep) inside
							FS_STROBE_HI, FS_STROBE_LO, FS_RAIL_HI: lim = regs.step_gap_ms;
							FS_RESET_LO: lim = regs.settle_gap_ms;
							default:     lim = regs.reset_pulse_ms;
						endcase
						gap_cnt = gap_cnt + 8'd1;
						// zero gap register fires on every ms tick
						if (gap_cnt >= lim || gap_cnt == 0) begin
							gap_cnt = '0;
							case (fstep)
								FS_STROBE_HI: begin strobe = 1'b1; fstep = FS_STROBE_LO; end
								FS_STROBE_LO: begin strobe = 1'b0; fstep = FS_RAIL_HI; end
								FS_RAIL_HI:   begin rail = 1'b1; fstep = FS_RESET_LO; end
								FS_RESET_LO:  begin rst_n = 1'b0; fstep = FS_RESET_HI; end
								default: begin
									rst_n     = 1'b1;
									ph        = PH_PRESS;
									press_cnt = '0;
									fstep     = FS_STROBE_HI;
								end
							endcase
						end
					end
				end
				default: ph = PH_PRESS;
			endcase
			r.rail_enable = rail;
			r.strobe_pin  = strobe;
			r.reset_out_n = rst_n;
			r.phase       = ph;
			pin_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pin_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: rail=%b strobe=%b rst_n=%b phase=%0d",
						got.rail_enable, got.strobe_pin, got.reset_out_n, got.phase);
			end else begin
				want = pin_q.pop_front();
				if (got.rail_enable !== want.rail_enable || got.strobe_pin !== want.strobe_pin ||
					got.reset_out_n !== want.reset_out_n || got.phase !== want.phase) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp rail=%b strobe=%b rst_n=%b phase=%0d, %s",
							want.rail_enable, want.strobe_pin, want.reset_out_n, want.phase,
							$sformatf("got rail=%b strobe=%b rst_n=%b phase=%0d",
								got.rail_enable, got.strobe_pin, got.reset_out_n, got.phase));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bss_in_if  req_if();
	bss_out_if rsp_if();
	bss_cfg_if cfg_if();

	boot_sequence_supervisor_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	supervisor_scoreboard sb = new();

	int      src_idle_pct = 0;
	int      stall_pct    = 0;
	int      hold_req     = 0;
	int      hold_left    = 0;
	int      press_goal   = 0;
	bit      allow_idle   = 1'b0;
	result_t rsp_beat;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			rsp_beat.rail_enable = rsp_if.rail_enable;
			rsp_beat.strobe_pin  = rsp_if.strobe_pin;
			rsp_beat.reset_out_n = rsp_if.reset_out_n;
			rsp_beat.phase       = phase_t'(rsp_if.phase);
			sb.check_result(rsp_beat);
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int pick_goal();
		int lo;
		int hi;
		int g;
		lo = int'(sb.regs.press_min_ms);
		hi = int'(sb.regs.press_max_ms);
		case ($urandom_range(9))
			0: g = lo;
			1: g = hi;
			2: g = lo + 1;
			3: g = hi - 1;
			4: g = $urandom_range(GOAL_CAP);
			default: g = (hi - lo >= 2) ? $urandom_range(hi - 1, lo + 1) : $urandom_range(GOAL_CAP);
		endcase
		if (g > GOAL_CAP)
			g = GOAL_CAP;
		if (g < 0)
			g = 0;
		return g;
	endfunction

	// steered by the predicted phase; about one item in ten is plain noise
	function automatic item_t gen_item();
		item_t it;
		it = item_t'(5'($urandom_range(31)));
		if ($urandom_range(99) >= 10) begin
			case (sb.ph)
				PH_PRESS: begin
					if (sb.press_cnt < press_goal) begin
						it.button_level = ($urandom_range(99) < 4);
						it.ms_tick      = ($urandom_range(99) < 80);
					end else begin
						it.button_level = 1'b1;
						press_goal      = pick_goal();
					end
				end
				PH_GOOD:  it.power_good = ($urandom_range(99) < 12);
				PH_READY: begin
					it.power_good  = ($urandom_range(99) >= 8);
					it.ready_level = allow_idle ? ($urandom_range(99) >= 30) : 1'b1;
				end
				PH_FAIL:  it.ms_tick = ($urandom_range(99) < 75);
				default: ;
			endcase
		end
		// idle is final: keep ready high unless a failure takes priority
		if (sb.ph == PH_READY && !allow_idle && it.power_good && !it.ready_level &&
			sb.coarse_cnt <= sb.regs.ready_limit_ticks)
			it.ready_level = 1'b1;
		return it;
	endfunction

	task automatic push_beat(item_t it);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.ms_tick      <= it.ms_tick;
		req_if.coarse_tick  <= it.coarse_tick;
		req_if.button_level <= it.button_level;
		req_if.power_good   <= it.power_good;
		req_if.ready_level  <= it.ready_level;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_input(it);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_regs(int pmin, int pmax, int rise, int rdy, int step, int settle,
		int pulse);
		drain();
		repeat (4) @(posedge clk);
		cfg_write(CFG_PRESS_MIN, 16'(pmin));
		cfg_write(CFG_PRESS_MAX, 16'(pmax));
		cfg_write(CFG_RISE_LIMIT, 16'(rise));
		cfg_write(CFG_READY_LIMIT, 16'(rdy));
		// gap registers take the low byte only
		cfg_write(CFG_STEP_GAP, {8'($urandom), 8'(step)});
		cfg_write(CFG_SETTLE_GAP, {8'($urandom), 8'(settle)});
		cfg_write(CFG_RESET_PULSE, {8'($urandom), 8'(pulse)});
		cfg_write(CFG_SPARE, 16'($urandom));
		cfg_if.valid <= 1'b0;
		press_goal = pick_goal();
	endtask

	task automatic run_random(int n, int idle_pct, int stall, bit pressure);
		src_idle_pct = idle_pct;
		stall_pct    = stall;
		for (int k = 0; k < n; k++) begin
			if (pressure && k == n / 3)
				hold_req = 1;
			if (pressure && k == 2 * n / 3)
				drain();
			push_beat(gen_item());
		end
	endtask

	initial begin
		req_if.valid        <= 1'b0;
		req_if.ms_tick      <= 1'b0;
		req_if.coarse_tick  <= 1'b0;
		req_if.button_level <= 1'b1;
		req_if.power_good   <= 1'b0;
		req_if.ready_level  <= 1'b1;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= CFG_PRESS_MIN;
		cfg_if.data         <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: beat bits are {ms, coarse, button, good, ready}
		load_regs(0, 3, 0, 0, 0, 1, 2);
		push_beat(5'b00101);  // release with empty count
		push_beat(5'b10001);
		push_beat(5'b00111);  // inside window
		push_beat(5'b01000);
		push_beat(5'b00000);  // rise timeout
		push_beat(5'b10000);  // zero gap: strobe high
		push_beat(5'b01111);
		push_beat(5'b10000);
		push_beat(5'b10000);
		push_beat(5'b10000);
		push_beat(5'b10000);
		push_beat(5'b10000);  // reset high, back to press
		push_beat(5'b10000);
		push_beat(5'b10000);
		push_beat(5'b10000);
		push_beat(5'b00100);  // press at max: rejected
		push_beat(5'b11011);
		push_beat(5'b00100);
		push_beat(5'b00010);
		push_beat(5'b01011);
		push_beat(5'b00010);  // timeout wins over ready
		repeat (6) push_beat(5'b10000);

		load_regs(2, 9, 3, 4, 1, 2, 3);
		run_random(300, 0, 0, 1'b0);
		load_regs(0, 5, 0, 0, 0, 0, 0);
		run_random(200, 45, 0, 1'b0);
		load_regs(4, 12, 8, 10, 2, 3, 4);
		run_random(250, 0, 45, 1'b1);
		load_regs(1, 6, 2, 6, 1, 1, 1);
		run_random(250, 6, 6, 1'b0);
		load_regs(0, 65535, 65535, 65535, 255, 255, 255);
		run_random(200, 0, 0, 1'b0);
		load_regs(65535, 0, 1, 1, 2, 2, 2);
		run_random(80, 45, 45, 1'b0);
		load_regs(16, 500, 50, 550, 5, 10, 100);
		run_random(150, 6, 6, 1'b0);
		load_regs(2, 9, 3, 4, 1, 2, 3);
		allow_idle = 1'b1;
		run_random(170, 6, 6, 1'b1);

		req_if.valid <= 1'b0;
		for (int w = 0; w < 2000 && sb.pending() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0d expected results never arrived", sb.pending());
		end
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
